[hw/rtl/set_insert_remove_table_defines.svh]
// ----------------------------------------------------------------------------
// Set insert/remove table: assertion macros
// Shared concurrent assertion forms used by the table's RTL.
// ----------------------------------------------------------------------------
`ifndef SET_INSERT_REMOVE_TABLE_DEFINES_SVH
`define SET_INSERT_REMOVE_TABLE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SIRT_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SIRT_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/sirt_pkg.sv]
// ----------------------------------------------------------------------------
// Set insert/remove table package
// Widths, operation and status codes, and the control word sent to the cells.
// ----------------------------------------------------------------------------
package sirt_pkg;

    // Default number of slots in the table.
    localparam int CAPACITY_DEF = 64;

    // Field widths of the input and result words.
    localparam int VALUE_W   = 32;
    localparam int OPCODE_W  = 1;
    localparam int STATUS_W  = 3;
    localparam int COUNT_W   = 7;
    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 16;

    // Operation codes carried on the input side band.
    localparam logic [OPCODE_W-1:0] OP_INSERT = 1'b0;
    localparam logic [OPCODE_W-1:0] OP_REMOVE = 1'b1;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        ST_INSERTED = 3'd0,
        ST_PRESENT  = 3'd1,
        ST_REMOVED  = 3'd2,
        ST_ABSENT   = 3'd3,
        ST_FULL     = 3'd4
    } status_t;

    // Update enables broadcast to every cell of the chain.
    typedef struct packed {
        logic insert_en;
        logic remove_en;
    } cell_ctrl_t;

endpackage

[hw/rtl/sirt_cell.sv]
// ----------------------------------------------------------------------------
// Set table cell
// Holds one slot, compares it with the broadcast value, and either loads a
// new value or takes its upper neighbour's entry when a removal closes a gap.
// ----------------------------------------------------------------------------
module sirt_cell (
    input  logic                          aclk,
    input  logic [sirt_pkg::VALUE_W-1:0]  value,
    input  sirt_pkg::cell_ctrl_t          ctrl,
    input  logic                          occupied,
    input  logic                          tail,
    input  logic [sirt_pkg::VALUE_W-1:0]  next_entry,
    input  logic                          shift_in,
    output logic [sirt_pkg::VALUE_W-1:0]  entry_out,
    output logic                          shift_out
);

    logic [sirt_pkg::VALUE_W-1:0] entry_reg;
    logic [sirt_pkg::VALUE_W-1:0] entry_next;
    logic                         hit;

    // A held slot matches when it equals the broadcast value.
    assign hit       = occupied && (entry_reg == value);
    // Every slot at or above the matching one moves down on a removal.
    assign shift_out = shift_in || hit;
    assign entry_out = entry_reg;

    // Next slot contents.
    always_comb begin
        entry_next = entry_reg;
        if (ctrl.insert_en && tail) begin
            entry_next = value;
        end else if (ctrl.remove_en && shift_out) begin
            entry_next = next_entry;
        end
    end

    // Slot storage; its contents are only read below the fill count.
    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

endmodule

[hw/rtl/sirt_chain.sv]
// ----------------------------------------------------------------------------
// Set table cell chain
// A row of cells, one per slot, linked so that each can take its upper
// neighbour's entry and pass the match flag on to the next cell up.
// ----------------------------------------------------------------------------
module sirt_chain #(
    parameter int CAPACITY = sirt_pkg::CAPACITY_DEF,
    localparam int CNT_W   = $clog2(CAPACITY + 1)
) (
    input  logic                          aclk,
    input  logic [sirt_pkg::VALUE_W-1:0]  value,
    input  sirt_pkg::cell_ctrl_t          ctrl,
    input  logic [CNT_W-1:0]              count,
    output logic                          any_hit
);

    logic [sirt_pkg::VALUE_W-1:0] entries [CAPACITY];
    logic [CAPACITY:0]            shift_chain;

    // No match below the lowest cell.
    assign shift_chain[0] = 1'b0;

    // One cell per slot; occupancy and the append position follow the count.
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic                         occupied;
        logic                         tail;
        logic [sirt_pkg::VALUE_W-1:0] upper;

        assign occupied = (count > CNT_W'(g));
        assign tail     = (count == CNT_W'(g));

        if (g == CAPACITY - 1) begin : g_top
            assign upper = entries[g];
        end else begin : g_mid
            assign upper = entries[g + 1];
        end

        sirt_cell u_cell (
            .aclk       (aclk),
            .value      (value),
            .ctrl       (ctrl),
            .occupied   (occupied),
            .tail       (tail),
            .next_entry (upper),
            .shift_in   (shift_chain[g]),
            .entry_out  (entries[g]),
            .shift_out  (shift_chain[g + 1])
        );
    end

    // The flag leaving the top cell says whether any slot matched.
    assign any_hit = shift_chain[CAPACITY];

endmodule

[hw/rtl/set_insert_remove_table.sv]
// ----------------------------------------------------------------------------
// Set insert/remove table
// Keeps a set of distinct 32-bit values packed in a row of slot cells.
// ----------------------------------------------------------------------------
// Usage:
//   Input words arrive on s_tvalid/s_tready with the value in s_tdata and the
//   operation (insert or remove) in s_tuser. Each accepted word yields exactly
//   one result word on m_tvalid/m_tready carrying a status and the new count.
//   A word is taken into the input register and resolved once the result
//   register can take it: every slot cell compares with the value at once and
//   the whole row shifts or loads in that same cycle, and the result word is
//   registered for the output. No new word is taken while one is pending: the
//   input register stays busy until the compare-and-update has been done.
//   The result sits in an output register; the next input word is accepted
//   while it waits. If the receiver stalls, the following word holds in the
//   table's input register until the result register frees up.
//   Reset (aresetn low, synchronous) empties the set and drops any pending
//   word or result. The slot contents are not cleared; only slots below the
//   count are ever looked at.
// ----------------------------------------------------------------------------
`include "set_insert_remove_table_defines.svh"

module set_insert_remove_table #(
    parameter int CAPACITY = sirt_pkg::CAPACITY_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // [31:0] value
    input  logic [sirt_pkg::S_TDATA_W-1:0]  s_tdata,
    // [0] opcode
    input  logic [sirt_pkg::OPCODE_W-1:0]   s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [2:0] status, [9:3] count, [15:10] zero
    output logic [sirt_pkg::M_TDATA_W-1:0]  m_tdata
);

    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int WIDE_W = CNT_W + sirt_pkg::COUNT_W;

    logic                               busy_reg;
    logic [sirt_pkg::OPCODE_W-1:0]      op_reg;
    logic [sirt_pkg::VALUE_W-1:0]       value_reg;
    logic [CNT_W-1:0]                   count_reg;
    logic [CNT_W-1:0]                   count_next;
    logic                               m_tvalid_reg;
    sirt_pkg::status_t                  status_reg;
    sirt_pkg::status_t                  status_next;
    logic [sirt_pkg::COUNT_W-1:0]       m_count_reg;
    logic [WIDE_W-1:0]                  count_wide;
    logic                               apply;
    logic                               any_hit;
    logic                               full;
    sirt_pkg::cell_ctrl_t               ctrl;

    // Input is taken whenever no word is waiting to be resolved.
    assign s_tready = !busy_reg;

    // The pending word is resolved once the result register can take it.
    assign apply = busy_reg && (!m_tvalid_reg || m_tready);
    assign full  = (count_reg == CNT_W'(CAPACITY));

    // Enables for the cells.
    always_comb begin
        ctrl.insert_en = apply && (op_reg == sirt_pkg::OP_INSERT) && !any_hit && !full;
        ctrl.remove_en = apply && (op_reg == sirt_pkg::OP_REMOVE) && any_hit;
    end

    sirt_chain #(
        .CAPACITY (CAPACITY)
    ) u_chain (
        .aclk    (aclk),
        .value   (value_reg),
        .ctrl    (ctrl),
        .count   (count_reg),
        .any_hit (any_hit)
    );

    // New count and status of the word being resolved.
    always_comb begin
        count_next  = count_reg;
        status_next = sirt_pkg::ST_ABSENT;
        if (op_reg == sirt_pkg::OP_INSERT) begin
            if (any_hit) begin
                status_next = sirt_pkg::ST_PRESENT;
            end else if (full) begin
                status_next = sirt_pkg::ST_FULL;
            end else begin
                status_next = sirt_pkg::ST_INSERTED;
            end
        end else begin
            if (any_hit) begin
                status_next = sirt_pkg::ST_REMOVED;
            end
        end
        if (ctrl.insert_en) begin
            count_next = count_reg + CNT_W'(1);
        end else if (ctrl.remove_en) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    // The reported count is the new count after the operation, taken modulo 128.
    assign count_wide = WIDE_W'(count_next);

    // Control and result registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg     <= 1'b0;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            count_reg <= count_next;
            if (s_tvalid && s_tready) begin
                busy_reg <= 1'b1;
            end else if (apply) begin
                busy_reg <= 1'b0;
            end
            if (apply) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            op_reg    <= s_tuser;
            value_reg <= s_tdata[sirt_pkg::VALUE_W-1:0];
        end
        if (apply) begin
            status_reg  <= status_next;
            m_count_reg <= count_wide[sirt_pkg::COUNT_W-1:0];
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(sirt_pkg::M_TDATA_W - sirt_pkg::STATUS_W - sirt_pkg::COUNT_W){1'b0}},
                       m_count_reg, status_reg};

    // The count never goes beyond the table size.
    `SIRT_ASSERT_SAME(a_count_bound, aclk, aresetn, 1'b1, count_reg <= CNT_W'(CAPACITY),
        "count exceeds capacity")
    // A refused insert is only reported with a full table.
    `SIRT_ASSERT_SAME(a_full_status, aclk, aresetn,
        m_tvalid_reg && (status_reg == sirt_pkg::ST_FULL), count_reg == CNT_W'(CAPACITY),
        "full status with room left")
    // A successful insert grows the count by one.
    `SIRT_ASSERT_NEXT(a_insert_count, aclk, aresetn, ctrl.insert_en,
        count_reg == CNT_W'($past(count_reg) + CNT_W'(1)), "insert did not grow count")
    // A successful removal shrinks the count by one.
    `SIRT_ASSERT_NEXT(a_remove_count, aclk, aresetn, ctrl.remove_en,
        count_reg == CNT_W'($past(count_reg) - CNT_W'(1)), "remove did not shrink count")
    // A word is never resolved while a result is still being held back.
    `SIRT_ASSERT_SAME(a_no_overwrite, aclk, aresetn, m_tvalid_reg && !m_tready, !apply,
        "result overwritten while stalled")

endmodule

[dv/tb_set_insert_remove_table.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Set insert/remove table testbench
// Sends insert and remove words into the table and compares each result word
// with a behavioural copy of the set kept alongside. A short table of directed
// words comes first. Random bursts follow that fill the table past capacity,
// drain it and mix both. Sender gaps and receiver stalls change between phases.
// ----------------------------------------------------------------------------
module tb_set_insert_remove_table;

    localparam int SLOTS        = sirt_pkg::CAPACITY_DEF;
    localparam int RANDOM_WORDS = 1200;
    localparam int POOL_N       = 80;
    localparam int DIR_N        = 18;
    localparam int MAX_REPORTS  = 10;

    // One result word: the status and the element count after the operation.
    typedef struct packed {
        sirt_pkg::status_t              status;
        logic [sirt_pkg::COUNT_W-1:0]   count;
    } outcome_t;

    // A directed row. Where fixed is set, the typed-in outcome is checked.
    typedef struct {
        logic [sirt_pkg::OPCODE_W-1:0]  op;
        logic [sirt_pkg::VALUE_W-1:0]   value;
        bit                             fixed;
        outcome_t                       res;
    } dir_row_t;

    logic                               aclk     = 1'b0;
    logic                               aresetn  = 1'b0;
    logic                               s_tvalid = 1'b0;
    logic                               s_tready;
    logic [sirt_pkg::S_TDATA_W-1:0]     s_tdata  = '0;
    logic [sirt_pkg::OPCODE_W-1:0]      s_tuser  = '0;
    logic                               m_tvalid;
    logic                               m_tready = 1'b0;
    logic [sirt_pkg::M_TDATA_W-1:0]     m_tdata;

    // Behavioural copy of the set, updated on every accepted word.
    logic [sirt_pkg::VALUE_W-1:0]       held_vals [SLOTS];
    int                                 held_n;

    // Outcomes awaited on the result side, oldest first.
    outcome_t                           awaited_q [$];
    // Per word sent: whether a typed-in outcome replaces the predicted one.
    dir_row_t                           sent_q [$];

    logic [sirt_pkg::VALUE_W-1:0]       pool [POOL_N];
    dir_row_t                           dir_rows [DIR_N];
    int                                 src_gap_pct;
    int                                 sink_stall_pct;
    int                                 mismatches;
    int                                 rand_sent;

    set_insert_remove_table uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),   // [31:0] value
        .s_tuser  (s_tuser),   // [0] opcode
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)    // [2:0] status, [9:3] count, [15:10] zero
    );

    // Clock.
    initial begin
        forever #5 aclk = ~aclk;
    end

    // Safety net against a hung handshake.
    initial begin
        #5ms;
        $display("Simulation FAILED");
        $finish;
    end

    // Applies one operation to the copy of the set and returns its outcome.
    function automatic outcome_t apply_set_op(logic [sirt_pkg::OPCODE_W-1:0] op,
                                              logic [sirt_pkg::VALUE_W-1:0] val);
        outcome_t r;
        int       slot;
        slot = -1;
        for (int i = 0; i < held_n; i++) begin
            if (slot < 0 && held_vals[i] == val) begin
                slot = i;
            end
        end
        if (op == sirt_pkg::OP_INSERT) begin
            if (slot >= 0) begin
                r.status = sirt_pkg::ST_PRESENT;
            end else if (held_n >= SLOTS) begin
                r.status = sirt_pkg::ST_FULL;
            end else begin
                held_vals[held_n] = val;
                held_n++;
                r.status = sirt_pkg::ST_INSERTED;
            end
        end else begin
            if (slot >= 0) begin
                // Close the gap; the vacated top slot is simply no longer counted.
                for (int j = slot; j + 1 < held_n; j++) begin
                    held_vals[j] = held_vals[j + 1];
                end
                held_n--;
                r.status = sirt_pkg::ST_REMOVED;
            end else begin
                r.status = sirt_pkg::ST_ABSENT;
            end
        end
        r.count = held_n[sirt_pkg::COUNT_W-1:0];
        return r;
    endfunction

    // Sends one word, with a random gap first, and returns once it is taken.
    task automatic send_word(input logic [sirt_pkg::OPCODE_W-1:0] op,
                             input logic [sirt_pkg::VALUE_W-1:0] val,
                             input bit fixed, input outcome_t res);
        dir_row_t note;
        note.op    = op;
        note.value = val;
        note.fixed = fixed;
        note.res   = res;
        while ($urandom_range(0, 99) < src_gap_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        sent_q.push_back(note);
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= val;
        @(posedge aclk);
        while (!s_tready) begin
            @(posedge aclk);
        end
    endtask

    task automatic send_random(input logic [sirt_pkg::OPCODE_W-1:0] op,
                               input logic [sirt_pkg::VALUE_W-1:0] val);
        // Idling regime follows progress through the random part.
        if (rand_sent < RANDOM_WORDS / 3) begin
            src_gap_pct    = 36;
            sink_stall_pct = 65;
        end else if (rand_sent < 2 * RANDOM_WORDS / 3) begin
            src_gap_pct    = 65;
            sink_stall_pct = 36;
        end else begin
            src_gap_pct    = 0;
            sink_stall_pct = 0;
        end
        send_word(op, val, 1'b0, '0);
        rand_sent++;
    endtask

    // Fresh pool of values; some differ from their neighbour in a single bit.
    task automatic refill_pool();
        for (int i = 0; i < POOL_N; i++) begin
            if (i > 0 && $urandom_range(0, 3) == 0) begin
                pool[i] = pool[i - 1] ^ (32'h1 << $urandom_range(0, 31));
            end else begin
                pool[i] = $urandom;
            end
        end
    endtask

    // Receiver readiness.
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end

    // Prediction on accepted input words, checking on accepted result words.
    always @(posedge aclk) begin
        dir_row_t note;
        outcome_t pred;
        outcome_t want;
        outcome_t got;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                note = sent_q.pop_front();
                pred = apply_set_op(s_tuser, s_tdata);
                awaited_q.push_back(note.fixed ? note.res : pred);
            end
            if (m_tvalid && m_tready) begin
                got.status = sirt_pkg::status_t'(m_tdata[sirt_pkg::STATUS_W-1:0]);
                got.count  = m_tdata[sirt_pkg::STATUS_W +: sirt_pkg::COUNT_W];
                if (awaited_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS) begin
                        $display("%0t: unexpected result word status=%0d count=%0d",
                                 $realtime, got.status, got.count);
                    end
                end else begin
                    want = awaited_q.pop_front();
                    if (got.status !== want.status || got.count !== want.count) begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS) begin
                            $display({"%0t: result mismatch: status exp %0d got %0d, ",
                                      "count exp %0d got %0d"},
                                     $realtime, want.status, got.status,
                                     want.count, got.count);
                        end
                    end
                end
            end
        end
    end

    // Stimulus and end of run.
    initial begin
        int                             kind;
        int                             len;
        int                             start;
        logic                           op_bit;
        logic [sirt_pkg::VALUE_W-1:0]   val;

        held_n         = 0;
        mismatches     = 0;
        rand_sent      = 0;
        src_gap_pct    = 36;
        sink_stall_pct = 65;

        // Directed words: extremes, removal from the middle, top and bottom,
        // removal of an absent value and refill of a vacated top slot.
        dir_rows = '{
            '{sirt_pkg::OP_REMOVE, 32'h0000_0000, 1'b1, '{sirt_pkg::ST_ABSENT,   7'd0}},
            '{sirt_pkg::OP_INSERT, 32'h0000_0000, 1'b1, '{sirt_pkg::ST_INSERTED, 7'd1}},
            '{sirt_pkg::OP_INSERT, 32'h0000_0000, 1'b1, '{sirt_pkg::ST_PRESENT,  7'd1}},
            '{sirt_pkg::OP_INSERT, 32'hFFFF_FFFF, 1'b1, '{sirt_pkg::ST_INSERTED, 7'd2}},
            '{sirt_pkg::OP_INSERT, 32'h8000_0000, 1'b0, '{sirt_pkg::ST_INSERTED, 7'd0}},
            '{sirt_pkg::OP_INSERT, 32'h0000_0001, 1'b0, '{sirt_pkg::ST_INSERTED, 7'd0}},
            '{sirt_pkg::OP_INSERT, 32'h7FFF_FFFF, 1'b0, '{sirt_pkg::ST_INSERTED, 7'd0}},
            '{sirt_pkg::OP_REMOVE, 32'h8000_0000, 1'b0, '{sirt_pkg::ST_INSERTED, 7'd0}},
            '{sirt_pkg::OP_REMOVE, 32'h7FFF_FFFF, 1'b0, '{sirt_pkg::ST_INSERTED, 7'd0}},
            '{sirt_pkg::OP_REMOVE, 32'h7FFF_FFFF, 1'b0, '{sirt_pkg::ST_INSERTED, 7'd0}},
            '{sirt_pkg::OP_INSERT, 32'h7FFF_FFFF, 1'b0, '{sirt_pkg::ST_INSERTED, 7'd0}},
            '{sirt_pkg::OP_REMOVE, 32'h0000_0000, 1'b0, '{sirt_pkg::ST_INSERTED, 7'd0}},
            '{sirt_pkg::OP_REMOVE, 32'h0000_0001, 1'b0, '{sirt_pkg::ST_INSERTED, 7'd0}},
            '{sirt_pkg::OP_INSERT, 32'h0000_0001, 1'b0, '{sirt_pkg::ST_INSERTED, 7'd0}},
            '{sirt_pkg::OP_REMOVE, 32'hFFFF_FFFF, 1'b0, '{sirt_pkg::ST_INSERTED, 7'd0}},
            '{sirt_pkg::OP_REMOVE, 32'h7FFF_FFFF, 1'b0, '{sirt_pkg::ST_INSERTED, 7'd0}},
            '{sirt_pkg::OP_REMOVE, 32'h0000_0001, 1'b0, '{sirt_pkg::ST_INSERTED, 7'd0}},
            '{sirt_pkg::OP_REMOVE, 32'hFFFF_FFFF, 1'b0, '{sirt_pkg::ST_INSERTED, 7'd0}}
        };

        // Reset.
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < DIR_N; i++) begin
            send_word(dir_rows[i].op, dir_rows[i].value, dir_rows[i].fixed, dir_rows[i].res);
        end

        // Random bursts. The first one fills the table, runs into the full
        // case and then offers values that are already held.
        refill_pool();
        kind = 0;
        while (rand_sent < RANDOM_WORDS) begin
            case (kind)
                0, 1, 2, 3: begin
                    // Fill: walk the pool inserting.
                    len   = (rand_sent == 0) ? POOL_N + 16 : $urandom_range(10, 90);
                    start = (rand_sent == 0) ? 0 : $urandom_range(0, POOL_N - 1);
                    for (int k = 0; k < len; k++) begin
                        send_random(sirt_pkg::OP_INSERT, pool[(start + k) % POOL_N]);
                    end
                end
                4, 5, 6: begin
                    // Drain: remove pool values, hits and misses both.
                    len = $urandom_range(10, 90);
                    for (int k = 0; k < len; k++) begin
                        send_random(sirt_pkg::OP_REMOVE, pool[$urandom_range(0, POOL_N - 1)]);
                    end
                end
                7, 8: begin
                    // Mixed operations, mostly on pool values.
                    len = $urandom_range(10, 40);
                    for (int k = 0; k < len; k++) begin
                        op_bit = $urandom_range(0, 1) ? sirt_pkg::OP_REMOVE
                                                      : sirt_pkg::OP_INSERT;
                        val    = ($urandom_range(0, 4) == 0) ? $urandom
                                                             : pool[$urandom_range(0, POOL_N - 1)];
                        send_random(op_bit, val);
                    end
                end
                default: begin
                    refill_pool();
                end
            endcase
            kind = $urandom_range(0, 9);
        end
        s_tvalid <= 1'b0;

        // Drain the outstanding results, then allow a few idle cycles.
        while (awaited_q.size() != 0 || sent_q.size() != 0) begin
            @(posedge aclk);
        end
        repeat (8) @(posedge aclk);

        if (mismatches == 0 && awaited_q.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

[filelist.f]
+incdir+hw/rtl
hw/rtl/sirt_pkg.sv
hw/rtl/sirt_cell.sv
hw/rtl/sirt_chain.sv
hw/rtl/set_insert_remove_table.sv
dv/tb_set_insert_remove_table.sv
